FILE: hdl/fpr_pkg.sv
package fpr_pkg;

    localparam int unsigned FRAME_COUNT_W   = 5;
    localparam int unsigned SLOT_W          = 4;
    localparam int unsigned FAULT_W         = 16;

    localparam logic [FRAME_COUNT_W-1:0] FRAME_COUNT_RST = 5'd4;
    localparam logic [FAULT_W-1:0]       FAULT_MAX       = 16'hFFFF;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CMP  = 3'b010,
        ST_RES  = 3'b100
    } fpr_state_t;

    typedef struct packed {
        logic valid;
        logic full;
    } fpr_queue_status_t;

endpackage

FILE: hdl/fpr_front.sv
module fpr_front #(
    parameter int unsigned PAGE_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [PAGE_BITS-1:0]          page_number,
    output fpr_pkg::fpr_queue_status_t    q_status,
    output logic [PAGE_BITS-1:0]          q_page,
    input  logic                          q_pop
);
    import fpr_pkg::*;

    logic [PAGE_BITS-1:0] queue_mem [2];
    logic [1:0]           count_reg;
    logic [1:0]           count_next;
    logic                 wr_ptr_reg;
    logic                 rd_ptr_reg;
    logic                 push;
    logic                 pop;

    assign q_status.valid = (count_reg != 2'd0);
    assign q_status.full  = (count_reg == 2'd2);
    assign in_ready       = !q_status.full;
    assign push           = in_valid && in_ready;
    assign pop            = q_pop && q_status.valid;
    assign q_page         = queue_mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_mem[wr_ptr_reg] <= page_number;
        end
    end

endmodule

FILE: hdl/fpr_back.sv
module fpr_back #(
    parameter int unsigned MAX_FRAMES = 16,
    parameter int unsigned PAGE_BITS  = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [fpr_pkg::FRAME_COUNT_W-1:0]   frame_count,
    input  fpr_pkg::fpr_queue_status_t          q_status,
    input  logic [PAGE_BITS-1:0]                q_page,
    output logic                                q_pop,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                hit,
    output logic [fpr_pkg::SLOT_W-1:0]          frame_slot,
    output logic                                evicted_valid,
    output logic [PAGE_BITS-1:0]                evicted_page,
    output logic [fpr_pkg::FAULT_W-1:0]         fault_total
);
    import fpr_pkg::*;

    localparam int unsigned IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int unsigned CNT_W = $clog2(MAX_FRAMES + 1);
    localparam int unsigned N_W   = (CNT_W > FRAME_COUNT_W) ? CNT_W : FRAME_COUNT_W;

    fpr_state_t                 state_reg;
    fpr_state_t                 state_next;
    logic [FRAME_COUNT_W-1:0]   frame_count_reg;
    logic [PAGE_BITS-1:0]       page_reg;
    logic [MAX_FRAMES-1:0]      match_reg;
    logic [MAX_FRAMES-1:0]      match_next;
    logic [PAGE_BITS-1:0]       frame_page_reg [MAX_FRAMES];
    logic [MAX_FRAMES-1:0]      frame_valid_reg;
    logic [CNT_W-1:0]           filled_reg;
    logic [IDX_W-1:0]           oldest_reg;
    logic [FAULT_W-1:0]         fault_reg;
    logic                       out_valid_reg;

    logic                       hit_reg;
    logic [SLOT_W-1:0]          slot_out_reg;
    logic                       ev_valid_reg;
    logic [PAGE_BITS-1:0]       ev_page_reg;

    logic [N_W-1:0]             fc_ext;
    logic [N_W-1:0]             n_wide;
    logic [CNT_W-1:0]           active_n;
    logic                       any_hit;
    logic [IDX_W-1:0]           hit_slot;
    logic [IDX_W-1:0]           wrap_slot;
    logic [CNT_W:0]             wrap_inc;
    logic                       not_full;
    logic [IDX_W-1:0]           slot_sel;
    logic                       ev_sel;
    logic                       retire;
    logic [IDX_W+SLOT_W-1:0]    slot_ext;

    assign cfg_ready = 1'b1;

    assign fc_ext   = N_W'(frame_count_reg);
    assign n_wide   = (fc_ext == '0) ? N_W'(1) :
                      (fc_ext > N_W'(MAX_FRAMES)) ? N_W'(MAX_FRAMES) : fc_ext;
    assign active_n = n_wide[CNT_W-1:0];

    always_comb
    begin
        for (int i = 0; i < MAX_FRAMES; i++)
        begin
            match_next[i] = frame_valid_reg[i] && (frame_page_reg[i] == page_reg)
                            && (CNT_W'(i) < active_n);
        end
    end

    always_comb
    begin
        any_hit  = |match_reg;
        hit_slot = '0;
        for (int i = MAX_FRAMES - 1; i >= 0; i--)
        begin
            if (match_reg[i])
            begin
                hit_slot = IDX_W'(i);
            end
        end
    end

    assign not_full  = (filled_reg < active_n);
    assign wrap_slot = (CNT_W'(oldest_reg) >= active_n) ? '0 : oldest_reg;
    assign wrap_inc  = (CNT_W + 1)'(wrap_slot) + (CNT_W + 1)'(1);
    assign slot_sel  = any_hit  ? hit_slot :
                       not_full ? filled_reg[IDX_W-1:0] : wrap_slot;
    assign ev_sel    = !any_hit && !not_full && frame_valid_reg[wrap_slot];
    assign slot_ext  = (IDX_W + SLOT_W)'(slot_sel);

    assign retire = (state_reg == ST_RES) && (!out_valid_reg || out_ready);
    assign q_pop  = (state_reg == ST_IDLE) && q_status.valid;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_status.valid)
                begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                state_next = ST_RES;
            end
            ST_RES:
            begin
                if (retire)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            frame_count_reg <= FRAME_COUNT_RST;
            frame_valid_reg <= '0;
            filled_reg      <= '0;
            oldest_reg      <= '0;
            fault_reg       <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                frame_count_reg <= frame_count;
            end
            if (retire)
            begin
                out_valid_reg <= 1'b1;
                if (!any_hit)
                begin
                    frame_valid_reg[slot_sel] <= 1'b1;
                    if (fault_reg != FAULT_MAX)
                    begin
                        fault_reg <= fault_reg + FAULT_W'(1);
                    end
                    if (not_full)
                    begin
                        filled_reg <= filled_reg + CNT_W'(1);
                    end
                    else
                    begin
                        oldest_reg <= (wrap_inc >= (CNT_W + 1)'(active_n)) ? '0 :
                                      wrap_inc[IDX_W-1:0];
                    end
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            page_reg <= q_page;
        end
        if (state_reg == ST_CMP)
        begin
            match_reg <= match_next;
        end
        if (retire)
        begin
            hit_reg      <= any_hit;
            slot_out_reg <= slot_ext[SLOT_W-1:0];
            ev_valid_reg <= ev_sel;
            ev_page_reg  <= ev_sel ? frame_page_reg[wrap_slot] : '0;
            if (!any_hit)
            begin
                frame_page_reg[slot_sel] <= page_reg;
            end
        end
    end

    assign fault_total   = fault_reg;
    assign out_valid     = out_valid_reg;
    assign hit           = hit_reg;
    assign frame_slot    = slot_out_reg;
    assign evicted_valid = ev_valid_reg;
    assign evicted_page  = ev_page_reg;

endmodule

FILE: hdl/fifo_page_replacement.sv
// Channel  | Handshake             | Payload
// ---------+-----------------------+--------------------------------------------------
// in       | in_valid / in_ready   | page_number
// out      | out_valid / out_ready | hit, frame_slot, evicted_valid, evicted_page,
//          |                       | fault_total
// cfg      | cfg_valid / cfg_ready | frame_count
//
// Each reference passes through the frame engine in order: dequeue, parallel compare
// against the frame table, then update and result write; the next waits for that loop.
// A two-entry queue ahead of the engine keeps taking transfers while it works, until full.
// Reset clears the valid bits, fill count, oldest pointer and fault count at once.
// A stalled result holds in the output register; the engine waits behind it.
module fifo_page_replacement #(
    parameter int unsigned MAX_FRAMES = 16,
    parameter int unsigned PAGE_BITS  = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [fpr_pkg::FRAME_COUNT_W-1:0]   frame_count,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [PAGE_BITS-1:0]                page_number,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                hit,
    output logic [fpr_pkg::SLOT_W-1:0]          frame_slot,
    output logic                                evicted_valid,
    output logic [PAGE_BITS-1:0]                evicted_page,
    output logic [fpr_pkg::FAULT_W-1:0]         fault_total
);
    import fpr_pkg::*;

    fpr_queue_status_t    q_status;
    logic [PAGE_BITS-1:0] q_page;
    logic                 q_pop;

    fpr_front #(
        .PAGE_BITS (PAGE_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .page_number (page_number),
        .q_status    (q_status),
        .q_page      (q_page),
        .q_pop       (q_pop)
    );

    fpr_back #(
        .MAX_FRAMES (MAX_FRAMES),
        .PAGE_BITS  (PAGE_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .frame_count   (frame_count),
        .q_status      (q_status),
        .q_page        (q_page),
        .q_pop         (q_pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .hit           (hit),
        .frame_slot    (frame_slot),
        .evicted_valid (evicted_valid),
        .evicted_page  (evicted_page),
        .fault_total   (fault_total)
    );

endmodule
